### rtl/core/cfe_pkg.sv
// Shared types and constants for the COBS frame encoder.
// Holds the byte kind codes and the command record passed from front to back.
// No dependencies.
`timescale 1ns / 1ps

package cfe_pkg;

  localparam int ADDR_W = 12;
  localparam int LEN_W  = 12;

  localparam logic [7:0] FULL_CODE  = 8'hFF;
  localparam logic [7:0] DELIM_BYTE = 8'h00;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_CODE  = 2'd1,
    KIND_DELIM = 2'd2
  } kind_t;

  // One accepted item, resolved into the writes it causes.
  typedef struct packed {
    logic              has_data;
    logic [ADDR_W-1:0] data_addr;
    logic [7:0]        data_val;
    logic              has_code;
    logic [ADDR_W-1:0] code_addr;
    logic [7:0]        code_val;
    logic              last;
    logic [ADDR_W-1:0] fin_addr;
    logic [7:0]        fin_val;
    logic [ADDR_W-1:0] delim_addr;
    logic [LEN_W-1:0]  length;
    logic              overflow;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

endpackage

### rtl/core/cobs_frame_encoder_core.sv
// Top level of the streaming COBS frame encoder.
// Instantiates cfe_front, cfe_queue and cfe_back; depends on cfe_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one frame byte per item with a
//   frame_last flag. Output channel (out_valid/out_ready) gives buffer writes:
//   address, value, kind, run_last on the final write of an item, the encoded
//   length on the delimiter write, and frame_overflow once a byte was dropped.
//   Timing:
//   The first write of an item passes through the command queue and the
//   output register before it is presented. The back end emits one write
//   per cycle while out_ready is high; an item causes one to four writes.
//   Items that cause a single write stream at one per cycle while it stays
//   high; the extra writes of a group close or a frame end are absorbed by
//   the four-entry command queue. A stalled receiver holds the output
//   register; the queue keeps taking items until it is full, then in_ready drops.
//   Reset clears the queue, the output register and the group state, so the
//   next item starts a new frame. The state also returns to its start values
//   after every frame_last item.
`timescale 1ns / 1ps

module cobs_frame_encoder_core import cfe_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 2048
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        data_byte,
  input  logic              frame_last,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ADDR_W-1:0] write_address,
  output logic [7:0]        write_value,
  output logic [1:0]        byte_kind,
  output logic              run_last,
  output logic [LEN_W-1:0]  encoded_length,
  output logic              frame_overflow
);

  logic  q_ready;
  logic  q_push;
  cmd_t  q_cmd;
  logic  q_pop;
  head_t q_head;

  cfe_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .frame_last(frame_last),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  cfe_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_cmd(q_cmd),
    .not_full(q_ready),
    .pop     (q_pop),
    .head    (q_head)
  );

  cfe_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (q_head),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .write_address (write_address),
    .write_value   (write_value),
    .byte_kind     (byte_kind),
    .run_last      (run_last),
    .encoded_length(encoded_length),
    .frame_overflow(frame_overflow)
  );

endmodule

### rtl/core/cfe_front.sv
// Front end of the COBS frame encoder: accepts items and keeps the group state.
// Produces one command per item that causes writes. Depends on cfe_pkg.
`timescale 1ns / 1ps

module cfe_front import cfe_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 2048
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       frame_last,
  input  logic       q_ready,
  output logic       q_push,
  output cmd_t       q_cmd
);

  // Positions can run a little past the byte bound because of code bytes.
  localparam int PW = $clog2(2 * MAX_FRAME_BYTES + 4);
  localparam int BW = $clog2(MAX_FRAME_BYTES + 1);

  logic [7:0]    group_code, group_code_next;
  logic [PW-1:0] code_slot, code_slot_next;
  logic [PW-1:0] next_write_pos, next_write_pos_next;
  logic [BW-1:0] bytes_taken, bytes_taken_next;
  logic          overflowed, overflowed_next;

  logic          accept;
  logic          at_bound;
  logic [PW-1:0] pos_plus1;
  logic [7:0]    code_plus1;

  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;
  assign at_bound = (bytes_taken == BW'(MAX_FRAME_BYTES));

  always_comb begin
    group_code_next     = group_code;
    code_slot_next      = code_slot;
    next_write_pos_next = next_write_pos;
    bytes_taken_next    = bytes_taken;
    overflowed_next     = overflowed | at_bound;
    pos_plus1           = next_write_pos + PW'(1);
    code_plus1          = group_code + 8'd1;
    q_cmd               = '0;

    if (!at_bound) begin
      bytes_taken_next = bytes_taken + BW'(1);
      if (data_byte == 8'h00) begin
        q_cmd.has_code      = 1'b1;
        q_cmd.code_addr     = ADDR_W'(code_slot);
        q_cmd.code_val      = group_code;
        group_code_next     = 8'd1;
        code_slot_next      = next_write_pos;
        next_write_pos_next = pos_plus1;
      end else begin
        q_cmd.has_data  = 1'b1;
        q_cmd.data_addr = ADDR_W'(next_write_pos);
        q_cmd.data_val  = data_byte;
        if (code_plus1 == FULL_CODE) begin
          // Group reached 254 data bytes: close it and open a fresh slot.
          q_cmd.has_code      = 1'b1;
          q_cmd.code_addr     = ADDR_W'(code_slot);
          q_cmd.code_val      = FULL_CODE;
          group_code_next     = 8'd1;
          code_slot_next      = pos_plus1;
          next_write_pos_next = pos_plus1 + PW'(1);
        end else begin
          group_code_next     = code_plus1;
          next_write_pos_next = pos_plus1;
        end
      end
    end

    q_cmd.last       = frame_last;
    q_cmd.fin_addr   = ADDR_W'(code_slot_next);
    q_cmd.fin_val    = group_code_next;
    q_cmd.delim_addr = ADDR_W'(next_write_pos_next);
    q_cmd.length     = LEN_W'(next_write_pos_next + PW'(1));
    q_cmd.overflow   = overflowed_next;
  end

  // A discarded byte that does not end the frame causes no writes.
  assign q_push = accept && (!at_bound || frame_last);

  always_ff @(posedge clk) begin
    if (rst || (accept && frame_last)) begin
      group_code     <= 8'd1;
      code_slot      <= '0;
      next_write_pos <= PW'(1);
      bytes_taken    <= '0;
      overflowed     <= 1'b0;
    end else if (accept) begin
      group_code     <= group_code_next;
      code_slot      <= code_slot_next;
      next_write_pos <= next_write_pos_next;
      bytes_taken    <= bytes_taken_next;
      overflowed     <= overflowed_next;
    end
  end

endmodule

### rtl/core/cfe_queue.sv
// Short command queue between the front and back ends of the COBS encoder.
// Four entries of cmd_t. Depends on cfe_pkg.
`timescale 1ns / 1ps

module cfe_queue import cfe_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  cmd_t  push_cmd,
  output logic  not_full,
  input  logic  pop,
  output head_t head
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign not_full   = (count != (PTR_W + 1)'(DEPTH));
  assign head.valid = (count != '0);
  assign head.cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (PTR_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (PTR_W + 1)'(1);
      end
    end
  end

endmodule

### rtl/core/cfe_back.sv
// Back end of the COBS encoder: expands the head command into buffer writes.
// Emits one write per cycle while out_ready allows, into an output register. Depends on cfe_pkg.
`timescale 1ns / 1ps

module cfe_back import cfe_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  head_t               head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ADDR_W-1:0]   write_address,
  output logic [7:0]          write_value,
  output logic [1:0]          byte_kind,
  output logic                run_last,
  output logic [LEN_W-1:0]    encoded_length,
  output logic                frame_overflow
);

  // Bit order: data, group code, final code, delimiter.
  logic [3:0] done;
  logic [3:0] pend;
  logic [3:0] sel;
  logic [3:0] rest;
  logic       fire;

  assign pend = head.valid
              ? ({head.cmd.last, head.cmd.last, head.cmd.has_code, head.cmd.has_data} & ~done)
              : 4'b0000;

  always_comb begin
    if (pend[0]) begin
      sel = 4'b0001;
    end else if (pend[1]) begin
      sel = 4'b0010;
    end else if (pend[2]) begin
      sel = 4'b0100;
    end else begin
      sel = {pend[3], 3'b000};
    end
  end

  assign rest = pend & ~sel;
  assign fire = (pend != 4'b0000) && (!out_valid || out_ready);
  assign pop  = fire && (rest == 4'b0000);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      done      <= '0;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
        done      <= pop ? 4'b0000 : (done | sel);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      run_last       <= (rest == 4'b0000);
      frame_overflow <= head.cmd.overflow;
      if (sel[0]) begin
        write_address  <= head.cmd.data_addr;
        write_value    <= head.cmd.data_val;
        byte_kind      <= KIND_DATA;
        encoded_length <= '0;
      end else if (sel[1]) begin
        write_address  <= head.cmd.code_addr;
        write_value    <= head.cmd.code_val;
        byte_kind      <= KIND_CODE;
        encoded_length <= '0;
      end else if (sel[2]) begin
        write_address  <= head.cmd.fin_addr;
        write_value    <= head.cmd.fin_val;
        byte_kind      <= KIND_CODE;
        encoded_length <= '0;
      end else begin
        write_address  <= head.cmd.delim_addr;
        write_value    <= DELIM_BYTE;
        byte_kind      <= KIND_DELIM;
        encoded_length <= head.cmd.length;
      end
    end
  end

endmodule

### rtl/core/cfe_checker.sv
// Port-level checks for the COBS frame encoder, bound to the top level.
// Depends on cfe_pkg.
`timescale 1ns / 1ps

module cfe_checker import cfe_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ADDR_W-1:0] write_address,
  input logic [7:0]        write_value,
  input logic [1:0]        byte_kind,
  input logic              run_last,
  input logic [LEN_W-1:0]  encoded_length
);

  // The output register comes out of reset empty.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // A stalled write keeps its address and value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(write_address) && $stable(write_value))
    else $error("stalled write changed");

  // The delimiter is always the last write of its item and carries a zero.
  a_delim: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_kind == KIND_DELIM |-> run_last && write_value == DELIM_BYTE)
    else $error("bad delimiter write");

  // Only the delimiter reports a length.
  a_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_kind != KIND_DELIM |-> encoded_length == '0)
    else $error("length on non-delimiter write");

  // Stuffed data never contains a zero byte.
  a_data_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_kind == KIND_DATA |-> write_value != 8'h00)
    else $error("zero data byte written");

endmodule

bind cobs_frame_encoder_core cfe_checker u_cfe_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .write_address (write_address),
  .write_value   (write_value),
  .byte_kind     (byte_kind),
  .run_last      (run_last),
  .encoded_length(encoded_length)
);
